// ===== sv/fbcd_pkg.sv =====
// shared constants, types and state encoding for the frame brightness change detector
package fbcd_pkg;

    localparam int unsigned MAX_FRAME_PIXELS = 4194304;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned RGB_W    = 10;
    localparam int unsigned SUM_W    = 30;
    localparam int unsigned COUNT_W  = 23;
    localparam int unsigned MEAN_W   = 8;
    localparam int unsigned FRAMES_W = 9;
    localparam int unsigned EVENTS_W = 16;
    localparam int unsigned STEP_W   = 3;

    // floor(x/3) for x <= 765 as (x * 683) >> 11
    localparam int unsigned DIV3_MUL   = 683;
    localparam int unsigned DIV3_SHIFT = 11;
    localparam int unsigned PROD_W     = 20;

    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 9'd511;
    localparam logic [EVENTS_W-1:0] EVENTS_MAX = 16'hFFFF;

    localparam logic [7:0] DEV_LIMIT_RESET = 8'd5;
    localparam logic [7:0] WARMUP_RESET    = 8'd50;

    localparam logic REG_DEV_LIMIT = 1'b0;
    localparam logic REG_WARMUP    = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_JUDGE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/fbcd_div.sv =====
// restoring divider: frame sum over pixel count, one quotient bit per cycle
module fbcd_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [fbcd_pkg::SUM_W-1:0]        dividend,
    input  logic [fbcd_pkg::COUNT_W-1:0]      divisor,
    output logic [fbcd_pkg::MEAN_W-1:0]       quotient,
    output fbcd_pkg::div_stat_t               stat
);

    logic [fbcd_pkg::SUM_W-1:0]  rem_reg, rem_next;
    logic [fbcd_pkg::SUM_W-1:0]  dvs_reg, dvs_next;
    logic [fbcd_pkg::MEAN_W-1:0] quo_reg, quo_next;
    logic [fbcd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        fits;

    // the single compare/subtract unit
    assign fits = (rem_reg >= dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            // quotient fits in 8 bits, so the divisor starts 7 places up
            dvs_next  = {divisor, {(fbcd_pkg::SUM_W - fbcd_pkg::COUNT_W){1'b0}}};
            quo_next  = '0;
            step_next = '1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            quo_next = {quo_reg[fbcd_pkg::MEAN_W-2:0], fits};
            dvs_next = dvs_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/frame_brightness_change_detector.sv =====
// top level: pixel accumulation, end-of-frame mean and brightness change judgment
//
// channel  dir  tdata (low bit up)                            side bands
// s_axis   in   red[7:0] green[15:8] blue[23:16]              tuser=in_region tlast=last_of_frame
// m_axis   out  event_res[0] frame_mean[8:1] deviation[16:9]  none
//               event_count[32:17] tracking[33]
// cfg      in   cfg_addr 0: dev_limit, 1: warmup_frames
//
// pixels that do not end a frame are taken one per cycle through a three-stage
// accumulate pipeline. after the last pixel of a frame tready stays low while the
// block drains the pipeline and loads the divider, runs the bit-serial divider
// (one compare/subtract per quotient bit), then judges and loads the result.
// the result register waits for m_axis_tready; the block stays in the judge
// step until that register is free. reset clears all counters and the frame sum.
module frame_brightness_change_detector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tuser,   // in_region
    input  logic        s_axis_tlast,   // last_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_res, frame_mean, deviation, event_count, tracking
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    fbcd_pkg::state_t state_reg, state_next;

    logic [7:0] dev_limit_reg;
    logic [7:0] warmup_reg;

    // pipeline stage 1: component sum
    logic                          s1_valid_reg;
    logic [fbcd_pkg::RGB_W-1:0]    s1_sum_reg;
    logic                          s1_region_reg;
    // pipeline stage 2: pixel intensity
    logic                          s2_valid_reg;
    logic [fbcd_pkg::PIX_W-1:0]    s2_int_reg;
    logic                          s2_region_reg;
    logic [fbcd_pkg::PROD_W-1:0]   div3_prod;

    logic [fbcd_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [fbcd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [fbcd_pkg::MEAN_W-1:0]   prev_mean_reg, prev_mean_next;
    logic [fbcd_pkg::FRAMES_W-1:0] frames_reg, frames_next;
    logic                          tracking_reg, tracking_next;
    logic [fbcd_pkg::EVENTS_W-1:0] events_reg, events_next;

    logic                          out_valid_reg, out_valid_next;
    logic [39:0]                   out_data_reg, out_data_next;

    logic                          in_fire;
    logic                          div_start;
    logic [fbcd_pkg::MEAN_W-1:0]   quotient;
    fbcd_pkg::div_stat_t           div_stat;

    // judgment terms
    logic [fbcd_pkg::MEAN_W-1:0]   mean;
    logic [fbcd_pkg::MEAN_W-1:0]   dev;
    logic [fbcd_pkg::FRAMES_W-1:0] frames_inc;
    logic                          track;
    logic                          event_hit;
    logic [fbcd_pkg::EVENTS_W-1:0] events_upd;

    assign s_axis_tready = (state_reg == fbcd_pkg::ST_RUN);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    fbcd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_limit_reg <= fbcd_pkg::DEV_LIMIT_RESET;
            warmup_reg    <= fbcd_pkg::WARMUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fbcd_pkg::REG_DEV_LIMIT: dev_limit_reg <= cfg_wdata;
                fbcd_pkg::REG_WARMUP:    warmup_reg    <= cfg_wdata;
                default:                 dev_limit_reg <= dev_limit_reg;
            endcase
        end
    end

    assign div3_prod = fbcd_pkg::PROD_W'(s1_sum_reg) * fbcd_pkg::PROD_W'(fbcd_pkg::DIV3_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg    <= fbcd_pkg::RGB_W'(s_axis_tdata[7:0]) + fbcd_pkg::RGB_W'(s_axis_tdata[15:8])
                       + fbcd_pkg::RGB_W'(s_axis_tdata[23:16]);
        s1_region_reg <= s_axis_tuser;
        s2_int_reg    <= div3_prod[fbcd_pkg::DIV3_SHIFT +: fbcd_pkg::PIX_W];
        s2_region_reg <= s1_region_reg;
    end

    // judgment of the finished frame
    always_comb
    begin
        mean = (count_reg == '0) ? '0 : quotient;
        dev  = (mean >= prev_mean_reg) ? (mean - prev_mean_reg) : (prev_mean_reg - mean);
        frames_inc = (frames_reg == fbcd_pkg::FRAMES_MAX) ? frames_reg : (frames_reg + 1'b1);
        track      = tracking_reg || (frames_inc > fbcd_pkg::FRAMES_W'(warmup_reg));
        event_hit  = track && (dev >= dev_limit_reg);
        events_upd = (events_reg == fbcd_pkg::EVENTS_MAX) ? events_reg : (events_reg + 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        div_start      = 1'b0;
        sum_next       = sum_reg;
        count_next     = count_reg;
        prev_mean_next = prev_mean_reg;
        frames_next    = frames_reg;
        tracking_next  = tracking_reg;
        events_next    = events_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        // oversized frames drop further pixels from count and sum
        if (s2_valid_reg && (count_reg < fbcd_pkg::COUNT_W'(fbcd_pkg::MAX_FRAME_PIXELS)))
        begin
            count_next = count_reg + 1'b1;
            if (s2_region_reg)
            begin
                sum_next = sum_reg + fbcd_pkg::SUM_W'(s2_int_reg);
            end
        end

        unique case (state_reg)
            fbcd_pkg::ST_RUN:
            begin
                if (in_fire && s_axis_tlast)
                begin
                    state_next = fbcd_pkg::ST_DRAIN;
                end
            end
            fbcd_pkg::ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    div_start  = 1'b1;
                    state_next = fbcd_pkg::ST_DIV;
                end
            end
            fbcd_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = fbcd_pkg::ST_JUDGE;
                end
            end
            fbcd_pkg::ST_JUDGE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, track,
                                      event_hit ? events_upd : events_reg,
                                      dev, mean, event_hit};
                    if (event_hit)
                    begin
                        events_next   = events_upd;
                        frames_next   = '0;
                        tracking_next = 1'b0;
                    end
                    else
                    begin
                        frames_next   = frames_inc;
                        tracking_next = track;
                    end
                    prev_mean_next = mean;
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = fbcd_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = fbcd_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbcd_pkg::ST_RUN;
            sum_reg       <= '0;
            count_reg     <= '0;
            prev_mean_reg <= '0;
            frames_reg    <= '0;
            tracking_reg  <= 1'b0;
            events_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            prev_mean_reg <= prev_mean_next;
            frames_reg    <= frames_next;
            tracking_reg  <= tracking_next;
            events_reg    <= events_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the frame brightness change detector stream block
module testbench;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 24;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_region;
        logic       last_px;
    } pixel_t;

    typedef struct {
        logic                          change_seen;
        logic [fbcd_pkg::MEAN_W-1:0]   mean;
        logic [fbcd_pkg::MEAN_W-1:0]   dev;
        logic [fbcd_pkg::EVENTS_W-1:0] change_total;
        logic                          tracking;
    } frame_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // red, green, blue
    logic        s_axis_tuser = 1'b0;  // in_region
    logic        s_axis_tlast = 1'b0;  // last_of_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // event_res, frame_mean, deviation, event_count, tracking
    logic        cfg_we = 1'b0;
    logic        cfg_addr = fbcd_pkg::REG_DEV_LIMIT;
    logic [7:0]  cfg_wdata = '0;

    pixel_t         pixel_queue[$];
    frame_verdict_t verdict_queue[$];

    // brightness tracker state mirrored from the block
    logic [fbcd_pkg::SUM_W-1:0]    luma_sum = '0;
    logic [fbcd_pkg::COUNT_W-1:0]  px_count = '0;
    logic [fbcd_pkg::MEAN_W-1:0]   prev_mean = '0;
    logic [fbcd_pkg::FRAMES_W-1:0] frames_since = '0;
    logic                          track_on = 1'b0;
    logic [fbcd_pkg::EVENTS_W-1:0] change_total = '0;
    logic [7:0]                    limit_cfg = fbcd_pkg::DEV_LIMIT_RESET;
    logic [7:0]                    warmup_cfg = fbcd_pkg::WARMUP_RESET;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [15:0] ready_mask = 16'hFFFF;

    frame_brightness_change_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // pixel sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin : pixel_driver
        pixel_t next_px;
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_queue.size() != 0)
            begin
                next_px = pixel_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {next_px.blue, next_px.green, next_px.red};
                s_axis_tuser <= next_px.in_region;
                s_axis_tlast <= next_px.last_px;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern rotates through a mask picked anew whenever the low cycle count bits wrap to zero
    always @(posedge clk)
    begin
        m_axis_tready <= ready_mask[cycle_count[3:0]];
        if (cycle_count[6:0] == 7'd0)
        begin
            case ($urandom_range(0, 3))
                0: ready_mask <= 16'hFFFF;
                1: ready_mask <= 16'h8000;
                default: ready_mask <= 16'($urandom) | 16'h0001;
            endcase
        end
    end

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // fold one accepted pixel into the frame sum; judge the frame on its last pixel
    task automatic take_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic region, input logic last_px);
        frame_verdict_t verdict;
        logic [fbcd_pkg::MEAN_W-1:0] mean;
        logic [fbcd_pkg::MEAN_W-1:0] dev;
        if (px_count < fbcd_pkg::MAX_FRAME_PIXELS)
        begin
            px_count = px_count + 1'b1;
            if (region)
                luma_sum = luma_sum + fbcd_pkg::SUM_W'((int'(r) + int'(g) + int'(b)) / 3);
        end
        if (last_px)
        begin
            mean = (px_count == 0) ? '0 : fbcd_pkg::MEAN_W'(luma_sum / px_count);
            if (frames_since < fbcd_pkg::FRAMES_MAX)
                frames_since = frames_since + 1'b1;
            if (frames_since > warmup_cfg)
                track_on = 1'b1;
            dev = (mean >= prev_mean) ? mean - prev_mean : prev_mean - mean;
            verdict.change_seen = 1'b0;
            verdict.tracking = track_on;
            if (track_on && dev >= limit_cfg)
            begin
                verdict.change_seen = 1'b1;
                if (change_total < fbcd_pkg::EVENTS_MAX)
                    change_total = change_total + 1'b1;
                frames_since = '0;
                track_on = 1'b0;
            end
            prev_mean = mean;
            luma_sum = '0;
            px_count = '0;
            verdict.mean = mean;
            verdict.dev = dev;
            verdict.change_total = change_total;
            verdict_queue.push_back(verdict);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        frame_verdict_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == fbcd_pkg::REG_DEV_LIMIT)
                    limit_cfg = cfg_wdata;
                else
                    warmup_cfg = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                take_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                           s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected frame result expected none actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    check_field("event_res", want.change_seen, m_axis_tdata[0]);
                    check_field("frame_mean", want.mean, m_axis_tdata[8:1]);
                    check_field("deviation", want.dev, m_axis_tdata[16:9]);
                    check_field("event_count", want.change_total, m_axis_tdata[32:17]);
                    check_field("tracking", want.tracking, m_axis_tdata[33]);
                end
            end
        end
    end

    // called at a falling edge so the queue never changes under the driver
    task automatic add_pixel(input int r, input int g, input int b,
                             input logic region, input logic last_px);
        pixel_t px;
        px.red = 8'(r);
        px.green = 8'(g);
        px.blue = 8'(b);
        px.in_region = region;
        px.last_px = last_px;
        pixel_queue.push_back(px);
    endtask

    // frame of len pixels scattered around one brightness level
    task automatic add_frame(input int len, input int level, input int spread, input int region_pct);
        int chan[3];
        for (int i = 0; i < len; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                chan[c] = level + int'($urandom_range(0, 2 * spread)) - spread;
                chan[c] = (chan[c] < 0) ? 0 : (chan[c] > 255) ? 255 : chan[c];
            end
            add_pixel(chan[0], chan[1], chan[2], $urandom_range(1, 100) <= region_pct,
                      i == len - 1);
        end
    endtask

    // stimulus waits until every queued pixel is sent and every frame result is back
    task automatic wait_idle();
        @(negedge clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || verdict_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int limit_pick;
        int warmup_pick;
        int items_sent;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: first frame compares against a zero mean
        add_pixel(255, 255, 255, 1'b1, 1'b1);
        add_pixel(255, 255, 255, 1'b1, 1'b0);
        add_pixel(0, 0, 0, 1'b1, 1'b0);
        add_pixel(255, 0, 0, 1'b0, 1'b0);
        add_pixel(0, 255, 0, 1'b1, 1'b1);
        // no pixel in the region gives a zero mean
        add_pixel(200, 100, 50, 1'b0, 1'b0);
        add_pixel(1, 2, 3, 1'b0, 1'b1);
        add_pixel(0, 0, 255, 1'b1, 1'b1);

        // zero limit and warm-up: every tracked frame is a change
        write_reg(fbcd_pkg::REG_DEV_LIMIT, 8'd0);
        write_reg(fbcd_pkg::REG_WARMUP, 8'd0);
        for (int i = 0; i < 6; i++)
            add_frame(1, (i % 2) * 255, 0, 100);

        // full limit: only a black to white swing counts
        write_reg(fbcd_pkg::REG_DEV_LIMIT, 8'd255);
        write_reg(fbcd_pkg::REG_WARMUP, 8'd2);
        add_pixel(0, 0, 0, 1'b1, 1'b1);
        add_pixel(0, 0, 0, 1'b1, 1'b1);
        add_pixel(0, 0, 0, 1'b1, 1'b1);
        add_pixel(255, 255, 255, 1'b1, 1'b1);
        add_pixel(0, 0, 0, 1'b1, 1'b1);
        add_pixel(255, 255, 255, 1'b1, 1'b1);
        add_pixel(40, 40, 40, 1'b1, 1'b1);

        // raising warm-up while tracking keeps it latched; frame counter saturates
        write_reg(fbcd_pkg::REG_WARMUP, 8'd255);
        for (int i = 0; i < 530; i++)
            add_frame(1, $urandom_range(60, 190), $urandom_range(0, 60), 80);
        write_reg(fbcd_pkg::REG_DEV_LIMIT, 8'd1);
        add_frame(2, 20, 0, 100);
        add_frame(2, 230, 0, 100);
        add_frame(2, 230, 0, 100);

        // random settings and frames
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            case ($urandom_range(0, 7))
                0, 1: limit_pick = 0;
                2: limit_pick = 255;
                default: limit_pick = $urandom_range(0, 20);
            endcase
            case ($urandom_range(0, 7))
                0, 1: warmup_pick = 0;
                2: warmup_pick = 255;
                default: warmup_pick = $urandom_range(0, 8);
            endcase
            write_reg(fbcd_pkg::REG_DEV_LIMIT, 8'(limit_pick));
            write_reg(fbcd_pkg::REG_WARMUP, 8'(warmup_pick));
            items_sent = 0;
            while (items_sent < 30)
            begin
                int len;
                len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                add_frame(len, $urandom_range(0, 255),
                          ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 40),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100) : 75);
                items_sent += len;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && verdict_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
